@@ sv/swmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package swmc_pkg;

   localparam int COORD_W = 7;
   localparam int LUT_W   = 16;

   typedef logic [COORD_W-1:0] coord_type;

   localparam logic [2:0] FUNC_UPDATE = 3'd0;
   localparam logic [2:0] FUNC_WRITE  = 3'd1;
   localparam logic [2:0] FUNC_READ   = 3'd2;
   localparam logic [2:0] FUNC_SWAP   = 3'd3;
   localparam logic [2:0] FUNC_CLEAR  = 3'd4;

   typedef struct packed {
      logic [2:0]         func;
      logic [9:0]         cell_index;
      logic signed [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               status;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [2:0]         func;
      logic [9:0]         cell_index;
      logic signed [31:0] write_value;
      coord_type          x;
      coord_type          y;
      coord_type          z;
      logic               bad;
   } cmd_type;

   typedef logic [127:0][LUT_W-1:0] lut_type;
   typedef logic [63:0][3:0]        div3_lut_type;

   function automatic lut_type build_tet();
      lut_type t;
      for (int i = 0; i < 128; i++) begin
         t[i] = LUT_W'((i * (i + 1) * (i + 2)) / 6);
      end
      return t;
   endfunction

   function automatic lut_type build_tri();
      lut_type t;
      for (int i = 0; i < 128; i++) begin
         t[i] = LUT_W'((i * (i + 1)) / 2);
      end
      return t;
   endfunction

   function automatic div3_lut_type build_div3();
      div3_lut_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 4'(i / 3);
      end
      return t;
   endfunction

   localparam lut_type      TET_LUT  = build_tet();
   localparam lut_type      TRI_LUT  = build_tri();
   localparam div3_lut_type DIV3_LUT = build_div3();

endpackage

`default_nettype wire

@@ sv/swmc_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swmc_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic [WIDTH-1:0] din,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] dout
);

   logic [1:0][WIDTH-1:0] slot_ff;
   logic [1:0]            count_ff, count_in;
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign dout    = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

@@ sv/swmc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swmc_front #(
   parameter int MESH_DIMENSION = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire swmc_pkg::req_type req_item,
   input  wire logic             init_busy,
   input  wire logic             cmd_full,
   output logic                  cmd_push,
   output swmc_pkg::cmd_type     cmd_item
);

   import swmc_pkg::*;

   localparam logic [LUT_W-1:0] UPD_LIMIT =
      LUT_W'((MESH_DIMENSION * (MESH_DIMENSION + 1) * (MESH_DIMENSION + 2)) / 6);
   localparam logic [LUT_W-1:0] STORE_LIMIT =
      LUT_W'(((MESH_DIMENSION + 1) * (MESH_DIMENSION + 2) * (MESH_DIMENSION + 3)) / 6);
   localparam coord_type DIM = COORD_W'(MESH_DIMENSION);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_X    = 4'b0010,
      F_Y    = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type  state_ff, state_in;
   cmd_type          item_ff, item_in;
   logic [LUT_W-1:0] r_ff, r_in;
   logic [LUT_W-1:0] idx_w, req_idx_w;
   coord_type        nx, ny;
   logic             req_bad;

   assign full      = (state_ff != F_IDLE) | init_busy;
   assign cmd_push  = (state_ff == F_PUSH) & ~cmd_full;
   assign cmd_item  = item_ff;
   assign idx_w     = LUT_W'(item_ff.cell_index);
   assign req_idx_w = LUT_W'(req_item.cell_index);
   assign nx        = item_ff.x + 1'b1;
   assign ny        = item_ff.y + 1'b1;

   always_comb begin
      unique case (req_item.func)
         FUNC_UPDATE:            req_bad = (req_idx_w >= UPD_LIMIT);
         FUNC_WRITE, FUNC_READ:  req_bad = (req_idx_w >= STORE_LIMIT);
         default:                req_bad = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      r_in     = r_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (push & ~full) begin
               item_in.func        = req_item.func;
               item_in.cell_index  = req_item.cell_index;
               item_in.write_value = req_item.write_value;
               item_in.x           = '0;
               item_in.y           = '0;
               item_in.z           = '0;
               item_in.bad         = req_bad;
               state_in = (req_item.func == FUNC_UPDATE && !req_bad) ? F_X : F_PUSH;
            end
         end
         F_X: begin
            // walk x up while the next layer still starts at or below the index
            if (nx < DIM && TET_LUT[nx] <= idx_w) begin
               item_in.x = nx;
            end else begin
               r_in     = idx_w - TET_LUT[item_ff.x];
               state_in = F_Y;
            end
         end
         F_Y: begin
            if (item_ff.y < item_ff.x && TRI_LUT[ny] <= r_ff) begin
               item_in.y = ny;
            end else begin
               item_in.z = COORD_W'(r_ff - TRI_LUT[item_ff.y]);
               state_in  = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!cmd_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      r_ff    <= r_in;
   end

endmodule

`default_nettype wire

@@ sv/swmc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module swmc_back #(
   parameter int MESH_DIMENSION = 16,
   parameter int VALUE_WIDTH    = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_empty,
   output logic                   cmd_pop,
   input  wire swmc_pkg::cmd_type cmd_head,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output swmc_pkg::rsp_type      rsp_item,
   output logic                   init_busy
);

   import swmc_pkg::*;

   localparam int DEPTH  =
      ((MESH_DIMENSION + 1) * (MESH_DIMENSION + 2) * (MESH_DIMENSION + 3)) / 6;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int VW     = VALUE_WIDTH;
   localparam int SW     = VW + 3;          // neighbour sum
   localparam int MW     = VW + 2;          // |sum| + 1
   localparam int DSTEPS = (MW + 3) / 4;    // radix-16 steps
   localparam int DVW    = DSTEPS * 4;
   localparam int DCW    = (DSTEPS > 1) ? $clog2(DSTEPS) : 1;
   localparam int QW     = VW + 2;
   localparam int DW     = VW + 3;
   localparam int EW     = VW + 32;

   localparam logic signed [DW-1:0] DIFF_HI = (DW'(1) << (VW - 1)) - DW'(1);
   localparam logic signed [DW-1:0] DIFF_LO = -DIFF_HI - DW'(1);
   localparam logic signed [EW-1:0] WR_HI   = (EW'(1) << (VW - 1)) - EW'(1);
   localparam logic signed [EW-1:0] WR_LO   = -WR_HI - EW'(1);
   localparam logic [AW-1:0]        LAST    = AW'(DEPTH - 1);
   localparam logic [DCW-1:0]       DLAST   = DCW'(DSTEPS - 1);
   localparam logic [2:0]           PREV_STEP = 3'd6;

   typedef enum logic [8:0] {
      B_INIT  = 9'b000000001,
      B_IDLE  = 9'b000000010,
      B_EXEC  = 9'b000000100,
      B_ADDR  = 9'b000001000,
      B_READ  = 9'b000010000,
      B_ACC   = 9'b000100000,
      B_DIV   = 9'b001000000,
      B_WRITE = 9'b010000000,
      B_RESP  = 9'b100000000
   } back_state_type;

   back_state_type         state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic                   role_ff, role_in;
   logic                   clr_item_ff, clr_item_in;
   logic [AW-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]          addr_ff, addr_in;
   logic [2:0]             step_ff, step_in;
   logic signed [SW-1:0]   acc_ff, acc_in;
   logic signed [VW-1:0]   prev_ff, prev_in;
   logic                   neg_ff, neg_in;
   logic [DVW-1:0]         dvd_ff, dvd_in;
   logic [DVW-1:0]         quo_ff, quo_in;
   logic [1:0]             rem_ff, rem_in;
   logic [DCW-1:0]         dcnt_ff, dcnt_in;
   logic signed [VW-1:0]   res_ff, res_in;
   logic                   status_ff, status_in;

   logic signed [VW-1:0]   grid_a_ff [0:DEPTH-1];
   logic signed [VW-1:0]   grid_b_ff [0:DEPTH-1];
   logic signed [VW-1:0]   rd_a_ff, rd_b_ff;
   logic signed [VW-1:0]   cur_rd, prv_rd;

   logic                   we_a, we_b;
   logic [AW-1:0]          wr_addr;
   logic signed [VW-1:0]   wr_data;

   logic signed [7:0]      na, nb, nc;
   logic [COORD_W-1:0]     fa, fb, fc, ft;
   logic [LUT_W-1:0]       fold_idx;

   logic [SW-1:0]          mag;
   logic [5:0]             dig;
   logic [3:0]             qd;
   logic signed [QW-1:0]   quot;
   logic signed [DW-1:0]   diff;
   logic signed [VW-1:0]   diff_sat;
   logic signed [EW-1:0]   wv_ext, res_ext;
   logic signed [VW-1:0]   wv_sat;

   assign cur_rd = role_ff ? rd_b_ff : rd_a_ff;
   assign prv_rd = role_ff ? rd_a_ff : rd_b_ff;

   // neighbour of the cell for this step, folded into the wedge
   always_comb begin
      na = signed'({1'b0, cmd_ff.x});
      nb = signed'({1'b0, cmd_ff.y});
      nc = signed'({1'b0, cmd_ff.z});
      ft = '0;
      case (step_ff)
         3'd0:    na = na - 8'sd1;
         3'd1:    na = na + 8'sd1;
         3'd2:    nb = nb - 8'sd1;
         3'd3:    nb = nb + 8'sd1;
         3'd4:    nc = nc - 8'sd1;
         default: nc = nc + 8'sd1;
      endcase
      fa = COORD_W'(na < 0 ? -na : na);
      fb = COORD_W'(nb < 0 ? -nb : nb);
      fc = COORD_W'(nc < 0 ? -nc : nc);
      if (fa < fb) begin ft = fa; fa = fb; fb = ft; end
      if (fa < fc) begin ft = fa; fa = fc; fc = ft; end
      if (fb < fc) begin ft = fb; fb = fc; fc = ft; end
      fold_idx = TET_LUT[fa] + TRI_LUT[fb] + LUT_W'(fc);
   end

   // rounding: (|sum| + 1) / 3 with the sign put back afterwards
   assign mag  = (acc_ff < 0) ? SW'(-acc_ff + SW'(1)) : SW'(acc_ff + SW'(1));
   assign dig  = {rem_ff, dvd_ff[DVW-1 -: 4]};
   assign qd   = DIV3_LUT[dig];
   assign quot = neg_ff ? -QW'(quo_ff) : QW'(quo_ff);
   assign diff = DW'(quot) - DW'(prev_ff);
   assign diff_sat = (diff > DIFF_HI) ? DIFF_HI[VW-1:0] :
                     (diff < DIFF_LO) ? DIFF_LO[VW-1:0] : diff[VW-1:0];

   assign wv_ext = EW'(cmd_ff.write_value);
   assign wv_sat = (wv_ext > WR_HI) ? WR_HI[VW-1:0] :
                   (wv_ext < WR_LO) ? WR_LO[VW-1:0] : wv_ext[VW-1:0];

   assign res_ext               = EW'(res_ff);
   assign rsp_item.result_value = res_ext[31:0];
   assign rsp_item.status       = status_ff;
   assign rsp_push              = (state_ff == B_RESP) & ~rsp_full;
   assign cmd_pop               = (state_ff == B_IDLE) & ~cmd_empty;
   assign init_busy             = (state_ff == B_INIT) & ~clr_item_ff;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      role_in     = role_ff;
      clr_item_in = clr_item_ff;
      clr_cnt_in  = clr_cnt_ff;
      addr_in     = addr_ff;
      step_in     = step_ff;
      acc_in      = acc_ff;
      prev_in     = prev_ff;
      neg_in      = neg_ff;
      dvd_in      = dvd_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      dcnt_in     = dcnt_ff;
      res_in      = res_ff;
      status_in   = status_ff;
      we_a        = 1'b0;
      we_b        = 1'b0;
      wr_addr     = AW'(cmd_ff.cell_index);
      wr_data     = wv_sat;
      unique case (state_ff)
         B_INIT: begin
            we_a       = 1'b1;
            we_b       = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST) begin
               clr_item_in = 1'b0;
               state_in    = clr_item_ff ? B_RESP : B_IDLE;
            end
         end
         B_IDLE: begin
            if (!cmd_empty) begin
               cmd_in   = cmd_head;
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            res_in    = '0;
            status_in = 1'b0;
            state_in  = B_RESP;
            if (cmd_ff.bad) begin
               status_in = 1'b1;
            end else begin
               unique case (cmd_ff.func)
                  FUNC_UPDATE: begin
                     step_in  = 3'd0;
                     acc_in   = '0;
                     state_in = B_ADDR;
                  end
                  FUNC_WRITE: begin
                     we_a = ~role_ff;
                     we_b = role_ff;
                  end
                  FUNC_READ: begin
                     addr_in  = AW'(cmd_ff.cell_index);
                     state_in = B_READ;
                  end
                  FUNC_SWAP: role_in = ~role_ff;
                  FUNC_CLEAR: begin
                     clr_cnt_in  = '0;
                     clr_item_in = 1'b1;
                     state_in    = B_INIT;
                  end
                  default: ;
               endcase
            end
         end
         B_ADDR: begin
            addr_in  = (step_ff == PREV_STEP) ? AW'(cmd_ff.cell_index) : AW'(fold_idx);
            state_in = B_READ;
         end
         B_READ: state_in = B_ACC;
         B_ACC: begin
            if (cmd_ff.func == FUNC_READ) begin
               res_in   = cur_rd;
               state_in = B_RESP;
            end else if (step_ff != PREV_STEP) begin
               acc_in   = acc_ff + SW'(cur_rd);
               step_in  = step_ff + 3'd1;
               state_in = B_ADDR;
            end else begin
               prev_in  = prv_rd;
               neg_in   = (acc_ff < 0);
               dvd_in   = DVW'(mag);
               quo_in   = '0;
               rem_in   = '0;
               dcnt_in  = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            quo_in  = {quo_ff[DVW-5:0], qd};
            rem_in  = 2'(dig - ({1'b0, qd, 1'b0} + {2'b00, qd}));
            dvd_in  = dvd_ff << 4;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DLAST) begin
               state_in = B_WRITE;
            end
         end
         B_WRITE: begin
            we_a     = role_ff;
            we_b     = ~role_ff;
            wr_data  = diff_sat;
            res_in   = diff_sat;
            state_in = B_RESP;
         end
         B_RESP: begin
            if (!rsp_full) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_INIT;
         role_ff     <= 1'b0;
         clr_item_ff <= 1'b0;
         clr_cnt_ff  <= '0;
         step_ff     <= '0;
         dcnt_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         role_ff     <= role_in;
         clr_item_ff <= clr_item_in;
         clr_cnt_ff  <= clr_cnt_in;
         step_ff     <= step_in;
         dcnt_ff     <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      addr_ff   <= addr_in;
      acc_ff    <= acc_in;
      prev_ff   <= prev_in;
      neg_ff    <= neg_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      res_ff    <= res_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (we_a) begin
         grid_a_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= grid_a_ff[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         grid_b_ff[wr_addr] <= wr_data;
      end
      rd_b_ff <= grid_b_ff[addr_ff];
   end

endmodule

`default_nettype wire

@@ sv/symmetric_waveguide_mesh_cell_update.sv @@
// Update: 7 reads (six neighbours, then the old value), each via address, read and accumulate,
//   then ceil((VALUE_WIDTH + 2) / 4) divide steps and a write-back; one read port per grid.
// Index decode in the front (walking x, then y) overlaps the previous item.
// Write, read and swap answer through the response state. Clear zeroes both grids.
// Reset is synchronous; afterwards a clearing pass over all tet(MESH_DIMENSION+1)
//   cells (969 by default) zeroes both grids, with full held high throughout.
`timescale 1ns / 1ps
`default_nettype none

module symmetric_waveguide_mesh_cell_update #(
   parameter int MESH_DIMENSION = 16,
   parameter int VALUE_WIDTH    = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire swmc_pkg::req_type req_item,
   output logic                   empty,
   input  wire logic              pop,
   output swmc_pkg::rsp_type      rsp_item
);

   import swmc_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   // front to back queue
   logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type            cmd_wr, cmd_rd;
   logic [CMD_W-1:0]   cmd_rd_bits;

   // back to result queue
   logic               res_push, res_full;
   rsp_type            res_wr;
   logic [RSP_W-1:0]   res_rd_bits;

   logic               init_busy;

   // Front: takes the transfer, range-checks and finds (x,y,z).
   swmc_front #(
      .MESH_DIMENSION (MESH_DIMENSION)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .init_busy (init_busy),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_item  (cmd_wr)
   );

   // Two-entry queue lets decode of the next item run during grid work.
   swmc_fifo #(
      .WIDTH (CMD_W)
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .full  (cmd_full),
      .din   (CMD_W'(cmd_wr)),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .dout  (cmd_rd_bits)
   );

   assign cmd_rd = cmd_type'(cmd_rd_bits);

   // Back: grids, neighbour gather, divide by three, write-back.
   swmc_back #(
      .MESH_DIMENSION (MESH_DIMENSION),
      .VALUE_WIDTH    (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_head  (cmd_rd),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp_item  (res_wr),
      .init_busy (init_busy)
   );

   // Result queue: a finished result waits here while the back moves on.
   swmc_fifo #(
      .WIDTH (RSP_W)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .full  (res_full),
      .din   (RSP_W'(res_wr)),
      .pop   (pop),
      .empty (empty),
      .dout  (res_rd_bits)
   );

   assign rsp_item = rsp_type'(res_rd_bits);

endmodule

`default_nettype wire
